// ----- hw/rtl/source_comment_stripper_unit_defines.svh -----
// Assertion macros for the comment stripper.
// Included by source_comment_stripper_unit; no other dependencies.
`ifndef SOURCE_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define SOURCE_COMMENT_STRIPPER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent holds, consequent holds in the same cycle.
`define SCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scs assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scs assertion failed");

`else

`define SCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/scs_pkg.sv -----
// Shared types and constants of the comment stripper.
// No dependencies; used by every module of the block.
`default_nettype none

package scs_pkg;

	localparam int LINE_COUNT_BITS = 16;
	localparam int LINE_NUM_W      = 16;
	localparam int MAX_RES         = 3;

	localparam logic [LINE_COUNT_BITS-1:0] LINE_ONE = LINE_COUNT_BITS'(1);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic                       held_bs;
		logic                       pend_v;
		logic [7:0]                 pend_b;
		logic                       in_blk;
		logic                       in_str;
		logic                       skip;
		logic                       kept_any;
		logic [LINE_COUNT_BITS-1:0] line_cnt;
	} state_t;

	typedef struct packed {
		logic [7:0]            data;
		logic                  line_end;
		logic [LINE_NUM_W-1:0] line_num;
	} res_t;

	typedef res_t [MAX_RES-1:0] res_arr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scs_step.sv -----
// Next-state and result logic for one request of the comment stripper.
// Depends on scs_pkg.
`default_nettype none

module scs_step (
	input  wire scs_pkg::state_t   state,
	input  wire logic [7:0]        byte_in,
	input  wire logic              is_line_end,
	output scs_pkg::state_t        state_nxt,
	output logic [1:0]             res_n,
	output scs_pkg::res_arr_t      res
);

	typedef struct packed {
		scs_pkg::state_t   st;
		logic [1:0]        n;
		scs_pkg::res_arr_t r;
	} work_t;

	function automatic work_t put_res(input work_t w, input logic [7:0] b, input logic le);
		if (w.n != 2'd3) begin
			w.r[w.n].data     = b;
			w.r[w.n].line_end = le;
			w.r[w.n].line_num = le ? scs_pkg::LINE_NUM_W'(w.st.line_cnt) : '0;
			w.n               = w.n + 2'd1;
		end
		return w;
	endfunction

	function automatic work_t keep(input work_t w, input logic [7:0] b);
		w             = put_res(w, b, 1'b0);
		w.st.kept_any = 1'b1;
		return w;
	endfunction

	// Judge ch against its lookahead; used is set when nxt is swallowed.
	function automatic work_t judge(input work_t w, input logic [7:0] ch,
			input logic [7:0] nxt, output logic used);
		used = 1'b0;
		if (w.st.in_blk) begin
			if (ch == scs_pkg::CH_STAR && nxt == scs_pkg::CH_SLASH) begin
				w.st.in_blk = 1'b0;
				used        = 1'b1;
			end
		end else begin
			if (ch == scs_pkg::CH_QUOTE)
				w.st.in_str = !w.st.in_str;
			if (ch == scs_pkg::CH_SLASH && !w.st.in_str && nxt == scs_pkg::CH_SLASH) begin
				w.st.skip = 1'b1;
			end else if (ch == scs_pkg::CH_SLASH && !w.st.in_str
					&& nxt == scs_pkg::CH_STAR) begin
				w.st.in_blk = 1'b1;
			end else if (ch == scs_pkg::CH_HASH) begin
				w.st.skip = 1'b1;
			end else begin
				w = keep(w, ch);
				if (ch == scs_pkg::CH_BSLASH) begin
					w    = keep(w, nxt);
					used = 1'b1;
				end
			end
		end
		return w;
	endfunction

	function automatic work_t feed(input work_t w, input logic [7:0] c);
		logic [7:0] p;
		logic       used;
		if (!w.st.skip) begin
			if (!w.st.pend_v) begin
				w.st.pend_b = c;
				w.st.pend_v = 1'b1;
			end else begin
				p           = w.st.pend_b;
				w.st.pend_v = 1'b0;
				w           = judge(w, p, c, used);
				if (!used && !w.st.skip) begin
					w.st.pend_b = c;
					w.st.pend_v = 1'b1;
				end
			end
		end
		return w;
	endfunction

	function automatic work_t close_line(input work_t w);
		logic used;
		if (w.st.pend_v && !w.st.skip)
			w = judge(w, w.st.pend_b, scs_pkg::CH_SPACE, used);
		if (w.st.kept_any)
			w = put_res(w, 8'h00, 1'b1);
		w.st.pend_v   = 1'b0;
		w.st.pend_b   = 8'h00;
		w.st.in_str   = 1'b0;
		w.st.skip     = 1'b0;
		w.st.kept_any = 1'b0;
		return w;
	endfunction

	work_t w;

	always_comb begin
		w.st = state;
		w.n  = 2'd0;
		w.r  = '0;
		if (is_line_end) begin
			w.st.line_cnt = w.st.line_cnt + scs_pkg::LINE_ONE;
			// a trailing backslash joins this line to the next
			if (w.st.held_bs)
				w.st.held_bs = 1'b0;
			else
				w = close_line(w);
		end else begin
			if (w.st.held_bs) begin
				w            = feed(w, scs_pkg::CH_BSLASH);
				w.st.held_bs = 1'b0;
			end
			if (byte_in == scs_pkg::CH_BSLASH)
				w.st.held_bs = 1'b1;
			else
				w = feed(w, byte_in);
		end
	end

	assign state_nxt = w.st;
	assign res_n     = w.n;
	assign res       = w.r;

endmodule

`default_nettype wire

// ----- hw/rtl/scs_run_buf.sv -----
// Result register of the comment stripper: holds the run of up to three
// results of one request and hands them out one per cycle unless stalled. Depends on scs_pkg.
`default_nettype none

module scs_run_buf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [1:0]                    load_n,
	input  wire scs_pkg::res_arr_t             load_res,
	output logic                               free,
	output logic                               strip_valid,
	input  wire logic                          strip_stall,
	output logic [7:0]                         out_byte,
	output logic                               out_line_end,
	output logic [scs_pkg::LINE_NUM_W-1:0]     line_number,
	output logic                               last_of_run
);

	scs_pkg::res_arr_t slot_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop  = strip_valid && !strip_stall;
	assign free = (cnt_q == 2'd0) || (pop && cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// advance the run towards slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= load_res;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	assign strip_valid  = (cnt_q != 2'd0);
	assign out_byte     = slot_q[0].data;
	assign out_line_end = slot_q[0].line_end;
	assign line_number  = slot_q[0].line_num;
	assign last_of_run  = (cnt_q == 2'd1);

endmodule

`default_nettype wire

// ----- hw/rtl/source_comment_stripper_unit.sv -----
// Comment stripper top level: input register, step logic, result register.
// Depends on scs_pkg, scs_step, scs_run_buf and the assertion macro header.
`default_nettype none

`include "source_comment_stripper_unit_defines.svh"

// Strips C-style comments from a text stream taken one request per byte, with a
// separate request marking each physical line end. A backslash last on a line
// joins it to the next; block comments span lines; line comments are dropped
// outside double-quoted strings; a hash drops the rest of the logical line. Each
// kept byte leaves as one result, and a logical line that kept any byte is closed
// by a line-end result carrying the physical line count. One request is taken per
// cycle while text_stall is low; a request yields zero to three results, and the
// single result register hands them out one per cycle unless strip_stall is high,
// so a request with results waits while an earlier run is still draining. Requests
// pass through the input register, then the result register.
module source_comment_stripper_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          text_valid,
	output logic                               text_stall,
	input  wire logic [7:0]                    byte_in,
	input  wire logic                          is_line_end,
	output logic                               strip_valid,
	input  wire logic                          strip_stall,
	output logic [7:0]                         out_byte,
	output logic                               out_line_end,
	output logic [scs_pkg::LINE_NUM_W-1:0]     line_number,
	output logic                               last_of_run
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       le_s1;

	// scanner state: lookahead byte, comment and string flags, line counter
	scs_pkg::state_t state_q;
	scs_pkg::state_t state_nxt;

	logic [1:0]        res_n;
	scs_pkg::res_arr_t res;
	logic              run_free;
	logic              process;

	scs_step u_step (
		.state       (state_q),
		.byte_in     (byte_s1),
		.is_line_end (le_s1),
		.state_nxt   (state_nxt),
		.res_n       (res_n),
		.res         (res)
	);

	// A request that yields nothing never waits on the result register.
	assign process    = valid_s1 && ((res_n == 2'd0) || run_free);
	assign text_stall = valid_s1 && !process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			byte_s1 <= byte_in;
			le_s1   <= is_line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (process) begin
			state_q <= state_nxt;
		end
	end

	scs_run_buf u_run_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (process && res_n != 2'd0),
		.load_n       (res_n),
		.load_res     (res),
		.free         (run_free),
		.strip_valid  (strip_valid),
		.strip_stall  (strip_stall),
		.out_byte     (out_byte),
		.out_line_end (out_line_end),
		.line_number  (line_number),
		.last_of_run  (last_of_run)
	);

	// A line-end result always closes its run and carries no text byte.
	`SCS_ASSERT_SAME(a_le_last, clk, arst_n, strip_valid && out_line_end, last_of_run)
	`SCS_ASSERT_SAME(a_le_zero, clk, arst_n, strip_valid && out_line_end, out_byte == 8'h00)
	// Every processed line-end request advances the physical line count by one.
	`SCS_ASSERT_NEXT(a_cnt_inc, clk, arst_n, process && le_s1, state_q.line_cnt == ($past(state_q.line_cnt) + scs_pkg::LINE_ONE))

endmodule

`default_nettype wire

// ----- bench/source_comment_stripper_unit_checker.sv -----
// Result checker for the comment stripper: predicts every result from the accepted
// text requests and compares it with what the block hands out.
// Depends on scs_pkg for the character codes and field widths.
module source_comment_stripper_unit_checker import scs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  text_valid,
	input  wire logic                  text_stall,
	input  wire logic [7:0]            byte_in,
	input  wire logic                  is_line_end,
	input  wire logic                  strip_valid,
	input  wire logic                  strip_stall,
	input  wire logic [7:0]            out_byte,
	input  wire logic                  out_line_end,
	input  wire logic [LINE_NUM_W-1:0] line_number,
	input  wire logic                  last_of_run,
	output int                         mismatch_count,
	output int                         results_due
);

	typedef struct packed {
		logic [7:0]            data;
		logic                  line_end;
		logic [LINE_NUM_W-1:0] line_num;
		logic                  last;
	} stripped_t;

	// predicted stripper state
	logic                       joined_bs;
	logic                       look_v;
	logic [7:0]                 look_b;
	logic                       in_block;
	logic                       in_quote;
	logic                       drop_line;
	logic                       line_has_text;
	logic [LINE_COUNT_BITS-1:0] phys_lines;

	stripped_t step_results[$];
	stripped_t stripped_due[$];
	stripped_t want;

	function automatic void emit_result(input logic [7:0] b, input logic le);
		stripped_t r;
		if (step_results.size() >= MAX_RES)
			return;
		r.data     = b;
		r.line_end = le;
		r.line_num = le ? LINE_NUM_W'(phys_lines) : '0;
		r.last     = 1'b0;
		step_results = {step_results, r};
	endfunction

	function automatic void keep_text(input logic [7:0] b);
		emit_result(b, 1'b0);
		line_has_text = 1'b1;
	endfunction

	// judge one byte against its lookahead; 1 when the lookahead is used up
	function automatic bit judge_char(input logic [7:0] ch, input logic [7:0] nxt);
		if (in_block) begin
			if (ch == CH_STAR && nxt == CH_SLASH) begin
				in_block = 1'b0;
				return 1'b1;
			end
			return 1'b0;
		end
		if (ch == CH_QUOTE)
			in_quote = !in_quote;
		if (ch == CH_SLASH && !in_quote) begin
			if (nxt == CH_SLASH) begin
				drop_line = 1'b1;
				return 1'b0;
			end
			if (nxt == CH_STAR) begin
				in_block = 1'b1;
				return 1'b0;
			end
		end
		if (ch == CH_HASH) begin
			drop_line = 1'b1;
			return 1'b0;
		end
		keep_text(ch);
		if (ch == CH_BSLASH) begin
			keep_text(nxt);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void feed_char(input logic [7:0] c);
		logic [7:0] p;
		bit         took;
		if (drop_line)
			return;
		if (!look_v) begin
			look_b = c;
			look_v = 1'b1;
			return;
		end
		p      = look_b;
		look_v = 1'b0;
		took   = judge_char(p, c);
		if (!took && !drop_line) begin
			look_b = c;
			look_v = 1'b1;
		end
	endfunction

	function automatic void close_line();
		if (look_v && !drop_line)
			void'(judge_char(look_b, CH_SPACE));
		if (line_has_text)
			emit_result(8'h00, 1'b1);
		look_v        = 1'b0;
		look_b        = 8'h00;
		in_quote      = 1'b0;
		drop_line     = 1'b0;
		line_has_text = 1'b0;
	endfunction

	function automatic void predict_stripped(input logic [7:0] b, input logic le);
		stripped_t r;
		step_results.delete();
		if (le) begin
			phys_lines = phys_lines + LINE_ONE;
			if (joined_bs)
				joined_bs = 1'b0;
			else
				close_line();
		end else begin
			if (joined_bs) begin
				feed_char(CH_BSLASH);
				joined_bs = 1'b0;
			end
			if (b == CH_BSLASH)
				joined_bs = 1'b1;
			else
				feed_char(b);
		end
		foreach (step_results[i]) begin
			r      = step_results[i];
			r.last = (i == step_results.size() - 1);
			stripped_due = {stripped_due, r};
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joined_bs      = 1'b0;
			look_v         = 1'b0;
			look_b         = 8'h00;
			in_block       = 1'b0;
			in_quote       = 1'b0;
			drop_line      = 1'b0;
			line_has_text  = 1'b0;
			phys_lines     = '0;
			stripped_due.delete();
			results_due    = 0;
			mismatch_count = 0;
		end else begin
			if (text_valid && !text_stall)
				predict_stripped(byte_in, is_line_end);
			if (strip_valid && !strip_stall) begin
				if (stripped_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %h line_end %b",
						out_byte, out_line_end));
				end else begin
					want = stripped_due.pop_front();
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte %h, predicted %h",
							out_byte, want.data));
					if (out_line_end !== want.line_end)
						report_mismatch($sformatf("out_line_end %b, predicted %b",
							out_line_end, want.line_end));
					if (line_number !== want.line_num)
						report_mismatch($sformatf("line_number %0d, predicted %0d",
							line_number, want.line_num));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %b, predicted %b",
							last_of_run, want.last));
				end
			end
			results_due = stripped_due.size();
		end
	end

endmodule

// ----- bench/source_comment_stripper_unit_tb.sv -----
// Top of the comment stripper testbench: clock, reset, text requests, result stalls
// and the verdict. Depends on scs_pkg, source_comment_stripper_unit and
// source_comment_stripper_unit_checker.
module source_comment_stripper_unit_tb;
	import scs_pkg::*;

	// cycles with no request or result moving before the run is called dead
	localparam int STALL_LIMIT = 500;

	logic                  clk;
	logic                  arst_n;
	logic                  text_valid;
	logic                  text_stall;
	logic [7:0]            byte_in;
	logic                  is_line_end;
	logic                  strip_valid;
	logic                  strip_stall;
	logic [7:0]            out_byte;
	logic                  out_line_end;
	logic [LINE_NUM_W-1:0] line_number;
	logic                  last_of_run;

	int mismatch_count;
	int results_due;
	int idle_cycles;
	int random_sent;
	bit quiet;

	source_comment_stripper_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.byte_in      (byte_in),
		.is_line_end  (is_line_end),
		.strip_valid  (strip_valid),
		.strip_stall  (strip_stall),
		.out_byte     (out_byte),
		.out_line_end (out_line_end),
		.line_number  (line_number),
		.last_of_run  (last_of_run)
	);

	source_comment_stripper_unit_checker strip_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_valid),
		.text_stall     (text_stall),
		.byte_in        (byte_in),
		.is_line_end    (is_line_end),
		.strip_valid    (strip_valid),
		.strip_stall    (strip_stall),
		.out_byte       (out_byte),
		.out_line_end   (out_line_end),
		.line_number    (line_number),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one request and hold it until taken. Entered and left at a falling edge;
	// valid is only lowered when a gap is drawn, so it never drops and rises in one step.
	task automatic send_request(input logic [7:0] b, input logic le);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid  <= 1'b1;
		byte_in     <= b;
		is_line_end <= le;
		do @(posedge clk); while (text_stall);
		@(negedge clk);
	endtask

	// line ends carry a random byte, which the block must ignore
	task automatic send_end();
		send_request(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], 1'b0);
	endtask

	task automatic send_line(input string s);
		send_string(s);
		send_end();
	endtask

	// Weight the alphabet towards the characters that steer the stripper.
	function automatic logic [7:0] pick_text_char();
		case ($urandom_range(0, 15))
			0:       return CH_QUOTE;
			1, 2:    return CH_SLASH;
			3, 4:    return CH_STAR;
			5:       return CH_HASH;
			6:       return CH_BSLASH;
			7:       return 8'($urandom_range(0, 255));
			8:       return CH_SPACE;
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	// A physical line of random text; now and then end it on a backslash so it
	// joins the next one.
	task automatic send_random_line();
		int len;
		len = $urandom_range(0, 8);
		repeat (len) send_request(pick_text_char(), 1'b0);
		if ($urandom_range(0, 5) == 0) begin
			send_request(CH_BSLASH, 1'b0);
			len++;
		end
		send_end();
		random_sent += len + 1;
	endtask

	// Result side: draw a stall for every result, then take the next one.
	initial begin
		int hold;
		strip_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				strip_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				strip_stall <= 1'b0;
			end
			do @(posedge clk); while (!strip_valid);
			@(negedge clk);
		end
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (text_valid && !text_stall) || (strip_valid && !strip_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int line_idx;
		arst_n      = 1'b0;
		text_valid  = 1'b0;
		byte_in     = 8'h00;
		is_line_end = 1'b0;
		quiet       = 1'b0;
		idle_cycles = 0;
		random_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// an empty line yields nothing
		send_end();
		// byte extremes, then a slash last on the line, judged against a space
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(CH_SLASH, 1'b0);
		send_end();
		// slash-star-slash opens and at once closes a block comment
		send_line("/*/x");
		// line comment inside a string is kept; a hash drops the rest even there
		send_line("\"//#z");
		// backslash at the end of a line joins it to the next, which opens a
		// block comment that only closes on the following line
		send_string("\\");
		send_end();
		send_line("/*");
		send_line("*/z");
		// backslash left pending when the logical line closes: kept with a space
		send_string("\\\\");
		send_end();
		send_end();

		line_idx = 0;
		while (random_sent < 100) begin
			// a stretch with no idling on either side
			quiet = (line_idx >= 2 && line_idx < 6);
			if (line_idx == 8) begin
				// hold the sender until every predicted result has come back
				text_valid <= 1'b0;
				@(negedge clk);
				while (results_due != 0) @(negedge clk);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_end();
				random_sent++;
			end else begin
				send_random_line();
			end
			line_idx++;
		end
		quiet = 1'b0;
		text_valid <= 1'b0;

		// drain, then allow the pipeline's latency for any stray result
		while (results_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
